/* rtl/core/packed_monomial_exponent_unit_top_defines.svh */
// ----------------------------------------------------------------------------
// Packed monomial exponent unit - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PACKED_MONOMIAL_EXPONENT_UNIT_TOP_DEFINES_SVH
`define PACKED_MONOMIAL_EXPONENT_UNIT_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define PMEU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define PMEU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pmeu_pkg.sv */
// ----------------------------------------------------------------------------
// Packed monomial exponent unit - package
// Field widths, mixed-radix weights and reciprocal constants.
// ----------------------------------------------------------------------------
`default_nettype none

package pmeu_pkg;

    localparam int WORD_W     = 32;
    localparam int POLY_BITS  = 25;
    localparam int EXT_BITS   = WORD_W - POLY_BITS;
    localparam int NUM_DIGITS = 6;
    localparam int IDX_W      = 4;

    localparam int D1_W = 7;
    localparam int D2_W = 6;
    localparam int D3_W = 5;
    localparam int D4_W = 4;
    localparam int D5_W = 3;
    localparam int D6_W = 2;

    // high part above the first digit (radix 128)
    localparam int HIGH_W = POLY_BITS - D1_W;

    localparam int RADIX_TWO   = 43;
    localparam int RADIX_THREE = 19;
    localparam int RADIX_FOUR  = 9;
    localparam int RADIX_FIVE  = 5;

    // divisors applied to the high part
    localparam longint DIV_Q2 = 43;
    localparam longint DIV_Q3 = 43 * 19;
    localparam longint DIV_Q4 = 43 * 19 * 9;
    localparam longint DIV_Q5 = 43 * 19 * 9 * 5;

    // floor(x / d) = (x * ceil(2^s / d)) >> s, s = HIGH_W + ceil(log2 d)
    localparam int SHIFT_Q2 = HIGH_W + 6;
    localparam int SHIFT_Q3 = HIGH_W + 10;
    localparam int SHIFT_Q4 = HIGH_W + 13;
    localparam int SHIFT_Q5 = HIGH_W + 16;

    localparam int RECIP_W = 20;
    localparam int PROD_W  = HIGH_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_Q2 =
        RECIP_W'(((64'd1 << SHIFT_Q2) + DIV_Q2 - 64'd1) / DIV_Q2);
    localparam logic [RECIP_W-1:0] RECIP_Q3 =
        RECIP_W'(((64'd1 << SHIFT_Q3) + DIV_Q3 - 64'd1) / DIV_Q3);
    localparam logic [RECIP_W-1:0] RECIP_Q4 =
        RECIP_W'(((64'd1 << SHIFT_Q4) + DIV_Q4 - 64'd1) / DIV_Q4);
    localparam logic [RECIP_W-1:0] RECIP_Q5 =
        RECIP_W'(((64'd1 << SHIFT_Q5) + DIV_Q5 - 64'd1) / DIV_Q5);

    localparam int Q2_W = 13;
    localparam int Q3_W = 9;
    localparam int Q4_W = 6;
    localparam int Q5_W = 3;

    localparam logic [WORD_W-1:0] WEIGHT [NUM_DIGITS] = '{
        32'd1, 32'd128, 32'd5504, 32'd104576, 32'd941184, 32'd4705920
    };

    function automatic logic [D6_W-1:0] mod3(input logic [Q5_W-1:0] q);
        logic [D6_W-1:0] r;
        unique case (q)
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            3'd2, 3'd5:       r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/packed_monomial_exponent_unit_top.sv */
// ----------------------------------------------------------------------------
// Packed monomial exponent unit - top level
// Decodes, adds and steps back packed mixed-radix monomial exponents.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | exp_a, exp_b
//  output  | out_valid/ out_ready | digit_one..digit_six, exterior_mask,
//          |                      | sum_exponent, shares_exterior,
//          |                      | prev_index, prev_exponent
//
//  One request per cycle while out_ready does not hold the output; the result
//  passes the input register, reciprocal-multiply register and result register.
//  Each stage moves when the stage after it is empty or moving, so a full
//  output waiting on out_ready still lets the earlier stages fill.
//  rst_n clears the stage valid flags only.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_monomial_exponent_unit_top
    import pmeu_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [WORD_W-1:0]        exp_a,
    input  wire logic [WORD_W-1:0]        exp_b,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [D1_W-1:0]               digit_one,
    output logic [D2_W-1:0]               digit_two,
    output logic [D3_W-1:0]               digit_three,
    output logic [D4_W-1:0]               digit_four,
    output logic [D5_W-1:0]               digit_five,
    output logic [D6_W-1:0]               digit_six,
    output logic [EXT_BITS-1:0]           exterior_mask,
    output logic [WORD_W-1:0]             sum_exponent,
    output logic                          shares_exterior,
    output logic signed [IDX_W-1:0]       prev_index,
    output logic [WORD_W-1:0]             prev_exponent
);

    logic en1;
    logic en2;

    logic              s0_valid_reg;
    logic [WORD_W-1:0] s0_a_reg;
    logic [WORD_W-1:0] s0_b_reg;

    logic              s1_valid_reg;
    logic [WORD_W-1:0] s1_a_reg;
    logic [HIGH_W-1:0] s1_high_reg;
    logic [Q2_W-1:0]   s1_q2_reg;
    logic [Q3_W-1:0]   s1_q3_reg;
    logic [Q4_W-1:0]   s1_q4_reg;
    logic [Q5_W-1:0]   s1_q5_reg;
    logic [WORD_W-1:0] s1_sum_reg;
    logic              s1_shares_reg;

    logic                    out_valid_reg;
    logic [D1_W-1:0]         digit_one_reg;
    logic [D2_W-1:0]         digit_two_reg;
    logic [D3_W-1:0]         digit_three_reg;
    logic [D4_W-1:0]         digit_four_reg;
    logic [D5_W-1:0]         digit_five_reg;
    logic [D6_W-1:0]         digit_six_reg;
    logic [EXT_BITS-1:0]     exterior_mask_reg;
    logic [WORD_W-1:0]       sum_exponent_reg;
    logic                    shares_exterior_reg;
    logic signed [IDX_W-1:0] prev_index_reg;
    logic [WORD_W-1:0]       prev_exponent_reg;

    // stage 1: quotients of the high part
    logic [HIGH_W-1:0] high0;
    logic [PROD_W-1:0] prod_q2;
    logic [PROD_W-1:0] prod_q3;
    logic [PROD_W-1:0] prod_q4;
    logic [PROD_W-1:0] prod_q5;
    logic [WORD_W-1:0] sum_next;

    // stage 2: remainders and predecessor
    logic [HIGH_W-1:0]       rem2;
    logic [Q2_W-1:0]         rem3;
    logic [Q3_W-1:0]         rem4;
    logic [Q4_W-1:0]         rem5;
    logic [D1_W-1:0]         digit_one_next;
    logic [D2_W-1:0]         digit_two_next;
    logic [D3_W-1:0]         digit_three_next;
    logic [D4_W-1:0]         digit_four_next;
    logic [D5_W-1:0]         digit_five_next;
    logic [D6_W-1:0]         digit_six_next;
    logic [NUM_DIGITS-1:0]   digit_nz;
    logic                    found;
    logic [WORD_W-1:0]       weight_sel;
    logic signed [IDX_W-1:0] prev_index_next;
    logic [WORD_W-1:0]       prev_exponent_next;

    assign en2      = !out_valid_reg || out_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = !s0_valid_reg || en1;

    assign high0   = s0_a_reg[POLY_BITS-1:D1_W];
    assign prod_q2 = PROD_W'(high0) * PROD_W'(RECIP_Q2);
    assign prod_q3 = PROD_W'(high0) * PROD_W'(RECIP_Q3);
    assign prod_q4 = PROD_W'(high0) * PROD_W'(RECIP_Q4);
    assign prod_q5 = PROD_W'(high0) * PROD_W'(RECIP_Q5);

    assign sum_next[POLY_BITS-1:0] = s0_a_reg[POLY_BITS-1:0] + s0_b_reg[POLY_BITS-1:0];
    assign sum_next[WORD_W-1:POLY_BITS] =
        s0_a_reg[WORD_W-1:POLY_BITS] ^ s0_b_reg[WORD_W-1:POLY_BITS];

    assign rem2 = s1_high_reg - HIGH_W'(HIGH_W'(s1_q2_reg) * HIGH_W'(RADIX_TWO));
    assign rem3 = s1_q2_reg - Q2_W'(Q2_W'(s1_q3_reg) * Q2_W'(RADIX_THREE));
    assign rem4 = s1_q3_reg - Q3_W'(Q3_W'(s1_q4_reg) * Q3_W'(RADIX_FOUR));
    assign rem5 = s1_q4_reg - Q4_W'(Q4_W'(s1_q5_reg) * Q4_W'(RADIX_FIVE));

    assign digit_one_next   = s1_a_reg[D1_W-1:0];
    assign digit_two_next   = rem2[D2_W-1:0];
    assign digit_three_next = rem3[D3_W-1:0];
    assign digit_four_next  = rem4[D4_W-1:0];
    assign digit_five_next  = rem5[D5_W-1:0];
    assign digit_six_next   = mod3(s1_q5_reg);

    assign digit_nz = {
        digit_six_next != '0, digit_five_next != '0, digit_four_next != '0,
        digit_three_next != '0, digit_two_next != '0, digit_one_next != '0
    };

    // lowest nonzero digit first, then lowest exterior flag
    always_comb
    begin
        found           = 1'b0;
        weight_sel      = '0;
        prev_index_next = '0;
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (!found && digit_nz[k])
            begin
                found           = 1'b1;
                weight_sel      = WEIGHT[k];
                prev_index_next = IDX_W'(k + 1);
            end
        end
        for (int k = 0; k < EXT_BITS; k++)
        begin
            if (!found && s1_a_reg[POLY_BITS+k])
            begin
                found           = 1'b1;
                weight_sel      = WORD_W'(1) << (POLY_BITS + k);
                prev_index_next = IDX_W'(-(k + 1));
            end
        end
        prev_exponent_next = found ? (s1_a_reg - weight_sel) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (en1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (en2)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s0_a_reg <= exp_a;
            s0_b_reg <= exp_b;
        end
        if (en1)
        begin
            s1_a_reg      <= s0_a_reg;
            s1_high_reg   <= high0;
            s1_q2_reg     <= Q2_W'(prod_q2 >> SHIFT_Q2);
            s1_q3_reg     <= Q3_W'(prod_q3 >> SHIFT_Q3);
            s1_q4_reg     <= Q4_W'(prod_q4 >> SHIFT_Q4);
            s1_q5_reg     <= Q5_W'(prod_q5 >> SHIFT_Q5);
            s1_sum_reg    <= sum_next;
            s1_shares_reg <= |(s0_a_reg[WORD_W-1:POLY_BITS] & s0_b_reg[WORD_W-1:POLY_BITS]);
        end
        if (en2)
        begin
            digit_one_reg       <= digit_one_next;
            digit_two_reg       <= digit_two_next;
            digit_three_reg     <= digit_three_next;
            digit_four_reg      <= digit_four_next;
            digit_five_reg      <= digit_five_next;
            digit_six_reg       <= digit_six_next;
            exterior_mask_reg   <= s1_a_reg[WORD_W-1:POLY_BITS];
            sum_exponent_reg    <= s1_sum_reg;
            shares_exterior_reg <= s1_shares_reg;
            prev_index_reg      <= prev_index_next;
            prev_exponent_reg   <= prev_exponent_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign digit_one       = digit_one_reg;
    assign digit_two       = digit_two_reg;
    assign digit_three     = digit_three_reg;
    assign digit_four      = digit_four_reg;
    assign digit_five      = digit_five_reg;
    assign digit_six       = digit_six_reg;
    assign exterior_mask   = exterior_mask_reg;
    assign sum_exponent    = sum_exponent_reg;
    assign shares_exterior = shares_exterior_reg;
    assign prev_index      = prev_index_reg;
    assign prev_exponent   = prev_exponent_reg;

endmodule

`default_nettype wire

/* rtl/core/pmeu_checker.sv */
// ----------------------------------------------------------------------------
// Packed monomial exponent unit - port checker
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packed_monomial_exponent_unit_top_defines.svh"

module pmeu_checker
    import pmeu_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_ready,
    input wire logic [WORD_W-1:0]        exp_a,
    input wire logic [WORD_W-1:0]        exp_b,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic [D1_W-1:0]          digit_one,
    input wire logic [D2_W-1:0]          digit_two,
    input wire logic [D3_W-1:0]          digit_three,
    input wire logic [D4_W-1:0]          digit_four,
    input wire logic [D5_W-1:0]          digit_five,
    input wire logic [D6_W-1:0]          digit_six,
    input wire logic [EXT_BITS-1:0]      exterior_mask,
    input wire logic [WORD_W-1:0]        sum_exponent,
    input wire logic                     shares_exterior,
    input wire logic signed [IDX_W-1:0]  prev_index,
    input wire logic [WORD_W-1:0]        prev_exponent
);

    `PMEU_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
        in_valid && $stable(exp_a) && $stable(exp_b),
        "request dropped or changed while waiting")

    `PMEU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(sum_exponent) && $stable(prev_exponent) && $stable(digit_one),
        "result changed while stalled")

    `PMEU_ASSERT_SAME(a_digit_range, out_valid,
        digit_two <= 6'd42 && digit_three <= 5'd18 && digit_four <= 4'd8 &&
        digit_five <= 3'd4 && digit_six <= 2'd2,
        "digit outside its radix")

    `PMEU_ASSERT_SAME(a_no_prev, out_valid && prev_index == 4'sd0,
        prev_exponent == 32'd0 && exterior_mask == 7'd0 && digit_one == 7'd0,
        "no predecessor reported for a nonzero exponent")

    `PMEU_ASSERT_SAME(a_shares_mask, out_valid && shares_exterior,
        exterior_mask != 7'd0,
        "shared exterior flag without exterior bits in A")

endmodule

bind packed_monomial_exponent_unit_top pmeu_checker u_pmeu_checker (.*);

`default_nettype wire
